// ----- rtl/core/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority queue
// Sizes, cell record, operation and status codes, and width helpers.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int CAPACITY      = 16;
   localparam int PRIORITY_BITS = 8;
   localparam int CNT_W         = $clog2(CAPACITY + 1);

   typedef logic [PRIORITY_BITS-1:0] prio_type;
   typedef logic [CNT_W-1:0]         count_type;

   // one stored item, with its occupancy flag
   typedef struct packed {
      logic     valid;
      logic [7:0] ch;
      prio_type prio;
   } slot_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_ENQ,
      OP_DEQ
   } op_type;

   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_DEQUEUED = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // broadcast to every cell in the row
   typedef struct packed {
      op_type     op;
      logic [7:0] ch;
      prio_type   prio;
   } cell_ctrl_type;

   localparam slot_type SLOT_EMPTY = '{valid: 1'b0, ch: 8'd0, prio: '0};

   // mask an input byte to the priority width
   function automatic prio_type prio_from_byte(input logic [7:0] b);
      prio_type r;
      r = '0;
      for (int i = 0; i < PRIORITY_BITS; i++) begin
         if (i < 8) begin
            r[i] = b[i];
         end
      end
      return r;
   endfunction

   // low byte of a priority value
   function automatic logic [7:0] byte_from_prio(input prio_type p);
      logic [7:0] r;
      r = 8'd0;
      for (int i = 0; i < 8; i++) begin
         if (i < PRIORITY_BITS) begin
            r[i] = p[i];
         end
      end
      return r;
   endfunction

   // low five bits of the item count
   function automatic logic [4:0] fill_from_count(input count_type c);
      logic [4:0] r;
      r = 5'd0;
      for (int i = 0; i < 5; i++) begin
         if (i < CNT_W) begin
            r[i] = c[i];
         end
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue row
// Holds one item; on enqueue it keeps, takes the new item or takes its left
// neighbor; on dequeue it takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  slot_type      left_slot,
   input  logic          left_le,
   input  slot_type      right_slot,
   output slot_type      slot,
   output logic          le
);

   logic       valid_ff, valid_in;
   logic [7:0] ch_ff, ch_in;
   prio_type   prio_ff, prio_in;

   assign slot = '{valid: valid_ff, ch: ch_ff, prio: prio_ff};

   // held item goes ahead of the new one when its priority is not larger
   assign le = valid_ff && (prio_ff <= ctrl.prio);

   // choose the next content of this slot
   always_comb begin
      valid_in = valid_ff;
      ch_in    = ch_ff;
      prio_in  = prio_ff;
      case (ctrl.op)
         OP_ENQ: begin
            if (!le) begin
               if (left_le) begin
                  valid_in = 1'b1;
                  ch_in    = ctrl.ch;
                  prio_in  = ctrl.prio;
               end else begin
                  valid_in = left_slot.valid;
                  ch_in    = left_slot.ch;
                  prio_in  = left_slot.prio;
               end
            end
         end
         OP_DEQ: begin
            valid_in = right_slot.valid;
            ch_in    = right_slot.ch;
            prio_in  = right_slot.prio;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff   <= ch_in;
      prio_ff <= prio_in;
   end

endmodule

// ----- rtl/core/stable_priority_queue.sv -----
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded priority queue built as a row of slot cells
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | action, item_char, item_priority
//   rsp     | out       | rsp_valid/rsp_stall | status, out_char, out_priority,
//           |           |                     | fill_count
//
// One operation per cycle while req_stall is low: the new priority is broadcast to every cell, each
// compares it with its own and the row shifts by at most one slot.
// The result is registered at the clock edge of the transfer.
// Reset clears the count and the cell valid bits directly; no sweep.
// While a result waits under rsp_stall, req_stall is raised.
// ----------------------------------------------------------------------------
module stable_priority_queue
   import spq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_action,
   input  logic [7:0] req_item_char,
   input  logic [7:0] req_item_priority,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_out_char,
   output logic [7:0] rsp_out_priority,
   output logic [4:0] rsp_fill_count
);

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    status_ff, status_in;
   logic [7:0]    out_char_ff, out_char_in;
   logic [7:0]    out_prio_ff, out_prio_in;
   logic [4:0]    fill_ff, fill_in;
   count_type     count_ff, count_in;
   logic          accept;
   cell_ctrl_type ctrl;
   slot_type      slots [CAPACITY];
   logic          les [CAPACITY];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // decode the request into a row operation and a result
   always_comb begin
      ctrl.op     = OP_NONE;
      ctrl.ch     = req_item_char;
      ctrl.prio   = prio_from_byte(req_item_priority);
      count_in    = count_ff;
      status_in   = ST_ENQUEUED;
      out_char_in = 8'd0;
      out_prio_in = 8'd0;
      if (req_action) begin
         if (count_ff == '0) begin
            status_in = ST_EMPTY;
         end else begin
            status_in   = ST_DEQUEUED;
            out_char_in = slots[0].ch;
            out_prio_in = byte_from_prio(slots[0].prio);
            count_in    = count_ff - 1'b1;
            ctrl.op     = accept ? OP_DEQ : OP_NONE;
         end
      end else begin
         if (count_ff >= count_type'(CAPACITY)) begin
            status_in = ST_FULL;
         end else begin
            count_in = count_ff + 1'b1;
            ctrl.op  = accept ? OP_ENQ : OP_NONE;
         end
      end
      fill_in = fill_from_count(count_in);
   end

   // row of cells, front item in cell zero
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      slot_type left_slot, right_slot;
      logic     left_le;
      if (i == 0) begin : g_head
         assign left_slot = SLOT_EMPTY;
         assign left_le   = 1'b1;
      end else begin : g_body
         assign left_slot = slots[i-1];
         assign left_le   = les[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_slot = SLOT_EMPTY;
      end else begin : g_inner
         assign right_slot = slots[i+1];
      end
      spq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .left_slot  (left_slot),
         .left_le    (left_le),
         .right_slot (right_slot),
         .slot       (slots[i]),
         .le         (les[i])
      );
   end

   // result register: load on transfer, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff   <= status_in;
         out_char_ff <= out_char_in;
         out_prio_ff <= out_prio_in;
         fill_ff     <= fill_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_char     = out_char_ff;
   assign rsp_out_priority = out_prio_ff;
   assign rsp_fill_count   = fill_ff;

endmodule

// ----- rtl/core/spq_checker.sv -----
// ----------------------------------------------------------------------------
// spq_checker: port-level checks of the stable priority queue
// Watches the result channel for held payloads and consistent status.
// ----------------------------------------------------------------------------
module spq_checker
   import spq_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_out_char,
   input logic [7:0] rsp_out_priority,
   input logic [4:0] rsp_fill_count
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_char) && $stable(rsp_fill_count))
      else $error("stalled result changed");

   // empty status only with nothing held
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_fill_count == 5'd0
         && rsp_out_char == 8'd0 && rsp_out_priority == 8'd0)
      else $error("empty status with items held");

   // full status only at capacity
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_fill_count == 5'(CAPACITY))
      else $error("full status below capacity");

   // a stored item leaves the count nonzero and no data
   a_enq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ENQUEUED |-> rsp_out_char == 8'd0
         && rsp_out_priority == 8'd0 && rsp_fill_count != 5'd0)
      else $error("enqueue result carries data");

   // no new transfer taken while a result is stalled
   a_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken under output stall");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_out_char     (rsp_out_char),
   .rsp_out_priority (rsp_out_priority),
   .rsp_fill_count   (rsp_fill_count)
);

// ----- dv/stable_priority_queue_tb.sv -----
// ----------------------------------------------------------------------------
// stable_priority_queue_tb: self-checking testbench of the stable priority queue
// Sends enqueue and dequeue transfers in gappy bursts against a stalling
// receiver. A shadow copy of the sorted queue predicts each result, and every
// result is compared field by field.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
   import spq_pkg::*;

   localparam logic ACT_ENQ       = 1'b0;
   localparam logic ACT_DEQ       = 1'b1;
   localparam int   IDLE_LIMIT    = 2000;
   localparam int   SETTLE_CYCLES = 8;
   localparam int   MAX_REPORTS   = 10;
   localparam int   LONG_HOLD     = 150;

   typedef struct {
      status_type status;
      logic [7:0] ch;
      logic [7:0] prio;
      logic [4:0] fill;
   } outcome_type;

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_stall;
   logic       req_action        = ACT_ENQ;
   logic [7:0] req_item_char     = 8'd0;
   logic [7:0] req_item_priority = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall         = 1'b0;
   logic [1:0] rsp_status;
   logic [7:0] rsp_out_char;
   logic [7:0] rsp_out_priority;
   logic [4:0] rsp_fill_count;

   // shadow copy of the sorted queue, front at index 0
   logic [7:0]  shadow_char [CAPACITY];
   prio_type    shadow_prio [CAPACITY];
   int          shadow_count = 0;
   outcome_type outcome_q[$];
   int          error_count  = 0;
   int          idle_cycles  = 0;

   // sender and receiver pacing
   bit tx_gappy     = 1'b0;
   int burst_left   = 0;
   bit rx_throttle  = 1'b0;
   int hold_request = 0;
   int hold_left    = 0;
   int run_left     = 0;
   bit stall_phase  = 1'b0;

   stable_priority_queue uut (.*);

   always #5 clock = ~clock;

   // apply one operation to the shadow queue and return the result it gives
   function automatic outcome_type apply_queue_op(input logic act, input logic [7:0] ch,
                                                  input logic [7:0] pr_byte);
      outcome_type o;
      prio_type    pr;
      int          pos;
      pr       = prio_type'(pr_byte);
      o.status = ST_ENQUEUED;
      o.ch     = 8'd0;
      o.prio   = 8'd0;
      if (act == ACT_DEQ) begin
         if (shadow_count == 0) begin
            o.status = ST_EMPTY;
         end else begin
            o.status = ST_DEQUEUED;
            o.ch     = shadow_char[0];
            o.prio   = 8'(shadow_prio[0]);
            for (int i = 1; i < shadow_count; i++) begin
               shadow_char[i-1] = shadow_char[i];
               shadow_prio[i-1] = shadow_prio[i];
            end
            shadow_count--;
         end
      end else if (shadow_count >= CAPACITY) begin
         o.status = ST_FULL;
      end else begin
         // go behind every held item of equal or lower priority value
         pos = 0;
         while (pos < shadow_count && shadow_prio[pos] <= pr) pos++;
         for (int i = shadow_count; i > pos; i--) begin
            shadow_char[i] = shadow_char[i-1];
            shadow_prio[i] = shadow_prio[i-1];
         end
         shadow_char[pos] = ch;
         shadow_prio[pos] = pr;
         shadow_count++;
      end
      o.fill = 5'(shadow_count);
      return o;
   endfunction

   function automatic void log_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
   endfunction

   // predict on each request transfer, check each result transfer
   always @(posedge clock) begin : check_results
      outcome_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            outcome_q.push_back(apply_queue_op(req_action, req_item_char, req_item_priority));
         end
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               log_mismatch($sformatf("unexpected result: st=%0d ch=%02h pr=%02h fill=%0d",
                  rsp_status, rsp_out_char, rsp_out_priority, rsp_fill_count));
            end else begin
               want = outcome_q.pop_front();
               if (rsp_status !== want.status || rsp_out_char !== want.ch ||
                   rsp_out_priority !== want.prio || rsp_fill_count !== want.fill) begin
                  log_mismatch($sformatf({"result mismatch: exp st=%0d ch=%02h pr=%02h ",
                     "fill=%0d, got st=%0d ch=%02h pr=%02h fill=%0d"},
                     want.status, want.ch, want.prio, want.fill,
                     rsp_status, rsp_out_char, rsp_out_priority, rsp_fill_count));
               end
            end
         end
      end
   end

   // end the run when no transfer happens for too long
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: long hold-off on request, else random runs of stall and ready
   always @(posedge clock) begin : receiver_pattern
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!rx_throttle) begin
         rsp_stall <= 1'b0;
      end else begin
         if (run_left == 0) begin
            stall_phase = ($urandom_range(0, 99) < 40);
            run_left    = $urandom_range(1, 8);
         end
         rsp_stall <= stall_phase;
         run_left--;
      end
   end

   // offer one item and hold it until the transfer
   task automatic send_item(input logic act, input logic [7:0] ch, input logic [7:0] pr);
      if (tx_gappy && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_item_char     <= ch;
      req_item_priority <= pr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left > 0) burst_left--;
   endtask

   // stop sending and wait until every expected result has come
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_random_enq(input bit narrow);
      send_item(ACT_ENQ, 8'($urandom),
                narrow ? 8'($urandom_range(0, 3)) : 8'($urandom));
   endtask

   task automatic send_random_deq();
      send_item(ACT_DEQ, 8'($urandom), 8'($urandom));
   endtask

   // extremes, equal-priority order, and dequeue while empty
   task automatic test_directed();
      tx_gappy    = 1'b0;
      rx_throttle = 1'b0;
      send_item(ACT_DEQ, 8'hFF, 8'hFF);
      send_item(ACT_ENQ, 8'h00, 8'hFF);
      send_item(ACT_ENQ, 8'hFF, 8'h00);
      send_item(ACT_ENQ, 8'h41, 8'h05);
      send_item(ACT_ENQ, 8'h42, 8'h05);
      send_item(ACT_ENQ, 8'h43, 8'h05);
      send_item(ACT_ENQ, 8'hA5, 8'hFF);
      send_item(ACT_ENQ, 8'h5A, 8'h80);
      repeat (7) send_item(ACT_DEQ, 8'h00, 8'h00);
      send_item(ACT_DEQ, 8'h00, 8'h00);
      wait_for_results();
   endtask

   // fill to capacity, enqueue while full, drain past empty
   task automatic test_fill_and_overflow();
      for (int r = 0; r < 3; r++) begin
         tx_gappy    = (r != 0);
         rx_throttle = (r == 2);
         repeat (CAPACITY + 2) send_random_enq(r == 1);
         // swap items while full
         repeat (4) begin
            send_random_deq();
            send_random_enq(r == 1);
            send_random_enq(r == 1);
         end
         repeat (CAPACITY + 2) send_random_deq();
      end
      wait_for_results();
   endtask

   // receiver holds off while the sender keeps offering items
   task automatic test_backpressure();
      tx_gappy     = 1'b0;
      rx_throttle  = 1'b0;
      hold_request = LONG_HOLD;
      repeat (40) begin
         if ($urandom_range(0, 99) < 60) send_random_enq(1'b0);
         else send_random_deq();
      end
      wait_for_results();
   endtask

   // random mix in phases of varying enqueue bias, priority range and pacing
   task automatic test_random_mix(input int n_items);
      int enq_pct;
      bit narrow;
      enq_pct = 50;
      narrow  = 1'b0;
      for (int k = 0; k < n_items; k++) begin
         if (k % 50 == 0) begin
            enq_pct     = $urandom_range(20, 80);
            narrow      = $urandom_range(0, 1);
            tx_gappy    = ($urandom_range(0, 2) != 0);
            rx_throttle = ($urandom_range(0, 2) != 0);
         end
         if ($urandom_range(0, 99) < enq_pct) send_random_enq(narrow);
         else send_random_deq();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_and_overflow();
      test_backpressure();
      test_random_mix(440);
      wait_for_results();
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
